// File: hw/rtl/touch_contact_slot_tracker_assert.svh
// Assertion macros for the slot tracker datapath.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef TOUCH_CONTACT_SLOT_TRACKER_ASSERT_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCST_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slot tracker assertion failed in %m");

// Next-cycle implication, checked outside reset.
`define TCST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slot tracker assertion failed in %m");

`endif

// File: hw/rtl/tcst_pkg.sv
`timescale 1ns / 1ps

package tcst_pkg;

   // Default slot count built into the table
   localparam int MAX_SLOTS_DEF = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS  = 2'd1;
   localparam logic                  PROTOCOL_TYPE_RST = 1'b1;
   localparam logic [CSR_DATA_W-1:0] ACTIVE_SLOTS_RST  = 5'd16;

   // Protocol select values
   localparam logic PROTO_A = 1'b0;
   localparam logic PROTO_B = 1'b1;

   // Request word kinds
   localparam logic MODE_CONTACT = 1'b0;
   localparam logic MODE_FLUSH   = 1'b1;

   // Field widths
   localparam int ID_W       = 16;
   localparam int POS_W      = 16;
   localparam int Z_W        = 16;
   localparam int SLOT_W     = 4;
   localparam int TID_W      = 17;
   localparam int PRES_W     = 15;
   localparam int DIST_W     = 16;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 88;

   // Tracking id of a released slot (-1)
   localparam logic [TID_W-1:0] TID_FREE = '1;

   // Response word kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ACK    = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_SYNC   = 2'd2
   } kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic scan_step;
      logic commit_ack;
      logic fl_read;
      logic fl_emit;
      logic fl_skip;
      logic load_sync;
   } tcst_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic idx_end;
      logic cur_dirty;
      logic out_free;
   } tcst_sts_type;

endpackage

// File: hw/rtl/tcst_ctrl.sv
`timescale 1ns / 1ps

module tcst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   input  tcst_pkg::tcst_sts_type sts,
   output tcst_pkg::tcst_cmd_type cmd
);
   import tcst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ACK,
      ST_FL_SCAN,
      ST_FL_EMIT,
      ST_SYNC
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // Sequence one word: search then acknowledge, or walk slots then sync
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = (req_tuser == MODE_FLUSH) ? ST_FL_SCAN : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (sts.idx_end) begin
               state_in = ST_ACK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_ACK: begin
            if (sts.out_free) begin
               cmd.commit_ack = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_FL_SCAN: begin
            if (sts.idx_end) begin
               state_in = ST_SYNC;
            end else if (sts.cur_dirty) begin
               cmd.fl_read = 1'b1;
               state_in    = ST_FL_EMIT;
            end else begin
               cmd.fl_skip = 1'b1;
            end
         end
         ST_FL_EMIT: begin
            if (sts.out_free) begin
               cmd.fl_emit = 1'b1;
               state_in    = ST_FL_SCAN;
            end
         end
         ST_SYNC: begin
            if (sts.out_free) begin
               cmd.load_sync = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state; ready is high exactly in idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

// File: hw/rtl/tcst_datapath.sv
`timescale 1ns / 1ps
`include "touch_contact_slot_tracker_assert.svh"

module tcst_datapath #(
   parameter int MaxSlots = tcst_pkg::MAX_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [tcst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcst_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [tcst_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  tcst_pkg::tcst_cmd_type            cmd,
   output tcst_pkg::tcst_sts_type            sts,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [tcst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [tcst_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);
   import tcst_pkg::*;

   localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int CntW = $clog2(MaxSlots + 1);
   localparam int CmpW = (CntW > CSR_DATA_W) ? CntW : CSR_DATA_W;
   localparam logic [CmpW-1:0] MaxSlotsCmp = CmpW'(MaxSlots);

   // Configuration registers
   logic                  protocol_ff, protocol_in;
   logic [CSR_DATA_W-1:0] active_ff, active_in;

   // Captured word
   logic [ID_W-1:0]         id_ff;
   logic [POS_W-1:0]        x_ff, y_ff;
   logic signed [Z_W-1:0]   z_ff;

   // Slot walk
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CmpW-1:0] n_lim, active_cmp, idx_cmp;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic            idx_end;

   // Slot table: flags in flops, payload in memory
   logic [MaxSlots-1:0] dirty_ff, dirty_in;
   logic [MaxSlots-1:0] busy_ff, busy_in;
   logic [ID_W-1:0]     owner_mem [MaxSlots];
   logic [POS_W-1:0]    x_mem     [MaxSlots];
   logic [POS_W-1:0]    y_mem     [MaxSlots];
   logic [Z_W-1:0]      z_mem     [MaxSlots];
   logic [ID_W-1:0]       rd_owner_ff;
   logic [POS_W-1:0]      rd_x_ff, rd_y_ff;
   logic signed [Z_W-1:0] rd_z_ff;
   logic                  mem_we, mem_re;

   // Search probe and results
   logic            probe_vld_ff, probe_vld_in;
   logic [IdxW-1:0] probe_idx_ff;
   logic            found_match_ff, found_match_in;
   logic            found_free_ff, found_free_in;
   logic [IdxW-1:0] match_idx_ff, match_idx_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic            found;

   // Output register
   logic              out_vld_ff, out_vld_in;
   logic              load_out;
   kind_type          out_kind_ff, out_kind_in;
   logic              out_status_ff, out_status_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [TID_W-1:0]  out_tid_ff, out_tid_in;
   logic [POS_W-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic              out_hp_ff, out_hp_in;
   logic [PRES_W-1:0] out_p_ff, out_p_in;
   logic              out_hd_ff, out_hd_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic              out_last_ff, out_last_in;

   // Decode register writes; unknown indexes drop
   always_comb begin
      protocol_in = protocol_ff;
      active_in   = active_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROTOCOL_TYPE: protocol_in = csr_wdata[0];
            CSR_ACTIVE_SLOTS:  active_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Limit the walk to the slots in use
   assign active_cmp = CmpW'(active_ff);
   assign n_lim      = (active_cmp > MaxSlotsCmp) ? MaxSlotsCmp : active_cmp;
   assign idx_cmp    = CmpW'(idx_ff);
   assign idx_end    = (idx_cmp >= n_lim);
   assign rd_addr    = idx_ff[IdxW-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_item) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.fl_emit || cmd.fl_skip) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Evaluate the registered probe read
   always_comb begin
      probe_vld_in   = cmd.scan_step;
      found_match_in = found_match_ff;
      found_free_in  = found_free_ff;
      match_idx_in   = match_idx_ff;
      free_idx_in    = free_idx_ff;
      if (cmd.load_item) begin
         found_match_in = 1'b0;
         found_free_in  = 1'b0;
      end else if (probe_vld_ff) begin
         if (protocol_ff == PROTO_B) begin
            if (!found_match_ff && busy_ff[probe_idx_ff] && (rd_owner_ff == id_ff)) begin
               found_match_in = 1'b1;
               match_idx_in   = probe_idx_ff;
            end
            if (!found_free_ff && !busy_ff[probe_idx_ff]) begin
               found_free_in = 1'b1;
               free_idx_in   = probe_idx_ff;
            end
         end else if (!found_free_ff && !dirty_ff[probe_idx_ff]) begin
            found_free_in = 1'b1;
            free_idx_in   = probe_idx_ff;
         end
      end
   end

   // Owner match wins over a free slot
   assign found   = found_match_ff || found_free_ff;
   assign wr_addr = found_match_ff ? match_idx_ff : free_idx_ff;
   assign mem_we  = cmd.commit_ack && found;
   assign mem_re  = cmd.scan_step || cmd.fl_read;

   // Update slot flags on commit and flush
   always_comb begin
      dirty_in = dirty_ff;
      busy_in  = busy_ff;
      if (mem_we) begin
         dirty_in[wr_addr] = 1'b1;
         busy_in[wr_addr]  = (z_ff != '0);
      end
      if (cmd.fl_emit) begin
         dirty_in[rd_addr] = 1'b0;
      end
   end

   // Build the next response word
   assign load_out = cmd.commit_ack || cmd.fl_emit || cmd.load_sync;

   always_comb begin
      out_kind_in   = KIND_SYNC;
      out_status_in = 1'b0;
      out_slot_in   = '0;
      out_tid_in    = '0;
      out_x_in      = '0;
      out_y_in      = '0;
      out_hp_in     = 1'b0;
      out_p_in      = '0;
      out_hd_in     = 1'b0;
      out_dist_in   = '0;
      out_last_in   = 1'b1;
      if (cmd.commit_ack) begin
         out_kind_in   = KIND_ACK;
         out_status_in = !found;
         out_slot_in   = found ? SLOT_W'(wr_addr) : '0;
         out_tid_in    = (found && (z_ff != '0)) ? {1'b0, id_ff} : TID_FREE;
      end else if (cmd.fl_emit) begin
         out_kind_in = KIND_REPORT;
         out_slot_in = SLOT_W'(rd_addr);
         out_tid_in  = busy_ff[rd_addr] ? {1'b0, rd_owner_ff} : TID_FREE;
         out_x_in    = rd_x_ff;
         out_y_in    = rd_y_ff;
         out_last_in = 1'b0;
         if (rd_z_ff > 0) begin
            out_hp_in = 1'b1;
            out_p_in  = rd_z_ff[PRES_W-1:0];
         end
         if (rd_z_ff < 0) begin
            out_hd_in   = 1'b1;
            out_dist_in = DIST_W'(-rd_z_ff);
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (load_out) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff    <= PROTOCOL_TYPE_RST;
         active_ff      <= ACTIVE_SLOTS_RST;
         idx_ff         <= '0;
         dirty_ff       <= '0;
         busy_ff        <= '0;
         probe_vld_ff   <= 1'b0;
         found_match_ff <= 1'b0;
         found_free_ff  <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         protocol_ff    <= protocol_in;
         active_ff      <= active_in;
         idx_ff         <= idx_in;
         dirty_ff       <= dirty_in;
         busy_ff        <= busy_in;
         probe_vld_ff   <= probe_vld_in;
         found_match_ff <= found_match_in;
         found_free_ff  <= found_free_in;
         out_vld_ff     <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         id_ff <= req_tdata[ID_W-1:0];
         x_ff  <= req_tdata[ID_W +: POS_W];
         y_ff  <= req_tdata[ID_W+POS_W +: POS_W];
         z_ff  <= req_tdata[ID_W+2*POS_W +: Z_W];
      end
      if (cmd.scan_step) begin
         probe_idx_ff <= rd_addr;
      end
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      if (load_out) begin
         out_kind_ff   <= out_kind_in;
         out_status_ff <= out_status_in;
         out_slot_ff   <= out_slot_in;
         out_tid_ff    <= out_tid_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_hp_ff     <= out_hp_in;
         out_p_ff      <= out_p_in;
         out_hd_ff     <= out_hd_in;
         out_dist_ff   <= out_dist_in;
         out_last_ff   <= out_last_in;
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[wr_addr] <= id_ff;
         x_mem[wr_addr]     <= x_ff;
         y_mem[wr_addr]     <= y_ff;
         z_mem[wr_addr]     <= z_ff;
      end
      if (mem_re) begin
         rd_owner_ff <= owner_mem[rd_addr];
         rd_x_ff     <= x_mem[rd_addr];
         rd_y_ff     <= y_mem[rd_addr];
         rd_z_ff     <= z_mem[rd_addr];
      end
   end

   // Status to the controller
   assign sts.idx_end   = idx_end;
   assign sts.cur_dirty = dirty_ff[rd_addr] && !idx_end;
   assign sts.out_free  = !out_vld_ff || rsp_tready;

   // Response ports
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_dist_ff, out_hd_ff, out_p_ff, out_hp_ff,
                        out_y_ff, out_x_ff, out_tid_ff, out_slot_ff, out_status_ff};

   `TCST_ASSERT_IMPLIES(a_load_when_free, load_out, sts.out_free)
   `TCST_ASSERT_IMPLIES(a_read_only_dirty, cmd.fl_read, sts.cur_dirty)
   `TCST_ASSERT_NEXT(a_emit_report, cmd.fl_emit, rsp_tvalid && (out_kind_ff == KIND_REPORT) && !out_last_ff)
   `TCST_ASSERT_NEXT(a_ack_last, cmd.commit_ack, rsp_tvalid && out_last_ff && (out_kind_ff == KIND_ACK))

endmodule

// File: hw/rtl/touch_contact_slot_tracker.sv
`timescale 1ns / 1ps

// Multitouch contact slot tracker. A contact word (req_tuser 0) picks a slot,
// under protocol A the first slot not yet updated this frame, under protocol B
// the slot owned by the same id or else the first free one, stores x, y and z
// there and answers with one acknowledge word (status 1 when no slot was
// found). A flush word (req_tuser 1) returns one report word per updated slot
// in use in index order, then a sync word with rsp_tlast high, and clears
// those slots' updated marks. Words are taken one at a time. Only the first n
// slots are searched or walked, n being active_slots capped at MAX_SLOTS. The
// slot walk visits one slot per cycle through a single registered read of the
// slot memory, except that each reported slot also waits until its report
// can enter the output register, which rsp_tready can hold back. Register
// writes on the csr_ port take effect on the next cycle and belong between
// words.
module touch_contact_slot_tracker #(
   parameter int MAX_SLOTS = tcst_pkg::MAX_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration writes
   input  logic                            csr_wr_en,
   input  logic [tcst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcst_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcst_pkg::REQ_DATA_W-1:0] req_tdata,  // contact_id, pos_x, pos_y, pos_z
   input  logic                            req_tuser,  // mode
   // Response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, slot_index, tracking_id, out_x, out_y, has_pressure, pressure,
   // has_distance, distance, one pad bit
   output logic [tcst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tcst_pkg::KIND_W-1:0]     rsp_tuser,  // kind
   output logic                            rsp_tlast
);
   import tcst_pkg::*;

   tcst_cmd_type cmd;
   tcst_sts_type sts;

   tcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcst_datapath #(
      .MaxSlots (MAX_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tcst_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 50;
   localparam int TOTAL_WORDS  = 260;   // directed words plus random ones
   localparam int PLAN_LEN     = 8;

   // Register indexes past the two real registers; writes there do nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // contact_id, pos_x, pos_y, pos_z
   logic                  req_tuser;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // status, slot_index, tracking_id, out_x, out_y, has_pressure, pressure,
   // has_distance, distance, one pad bit
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;   // kind
   logic                  rsp_tlast;

   touch_contact_slot_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // One response word, split into its fields
   typedef struct {
      kind_type           kind;
      logic               status;
      logic [SLOT_W-1:0]  slot;
      logic [TID_W-1:0]   tid;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic               has_pres;
      logic [PRES_W-1:0]  pres;
      logic               has_dist;
      logic [DIST_W-1:0]  dist_val;
      logic               last;
   } touch_reply_type;

   // Slot table mirror plus the queue of replies the block still owes
   class slot_reply_board;
      logic                  protocol;
      logic [CSR_DATA_W-1:0] slot_limit;
      logic [TID_W-1:0]      owner [MAX_SLOTS_DEF];
      logic [POS_W-1:0]      pos_x [MAX_SLOTS_DEF];
      logic [POS_W-1:0]      pos_y [MAX_SLOTS_DEF];
      logic signed [Z_W-1:0] pos_z [MAX_SLOTS_DEF];
      bit                    updated [MAX_SLOTS_DEF];
      touch_reply_type       awaited_replies [$];
      int                    error_count;

      function new();
         protocol    = PROTOCOL_TYPE_RST;
         slot_limit  = ACTIVE_SLOTS_RST;
         error_count = 0;
         for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
            owner[i]   = TID_FREE;
            pos_x[i]   = '0;
            pos_y[i]   = '0;
            pos_z[i]   = '0;
            updated[i] = 1'b0;
         end
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_PROTOCOL_TYPE) begin
            protocol = val[0];
         end else if (idx == CSR_ACTIVE_SLOTS) begin
            slot_limit = val;
         end
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction

      function touch_reply_type make_reply(kind_type kind, logic status, int slot,
                                           logic [TID_W-1:0] tid, logic [POS_W-1:0] x,
                                           logic [POS_W-1:0] y, logic signed [Z_W-1:0] z,
                                           logic last);
         touch_reply_type r;
         int zi;
         zi         = z;
         r.kind     = kind;
         r.status   = status;
         r.slot     = SLOT_W'(slot);
         r.tid      = tid;
         r.x        = x;
         r.y        = y;
         r.has_pres = (zi > 0);
         r.pres     = (zi > 0) ? PRES_W'(zi) : '0;
         r.has_dist = (zi < 0);
         r.dist_val = (zi < 0) ? DIST_W'(-zi) : '0;
         r.last     = last;
         return r;
      endfunction

      // Protocol A: first slot not updated. Protocol B: same owner, else first free.
      function int find_slot(logic [ID_W-1:0] id, int n);
         if (protocol == PROTO_A) begin
            for (int i = 0; i < n; i++)
               if (!updated[i]) return i;
            return -1;
         end
         for (int i = 0; i < n; i++)
            if (owner[i] == {1'b0, id}) return i;
         for (int i = 0; i < n; i++)
            if (owner[i] == TID_FREE) return i;
         return -1;
      endfunction

      function void predict_replies(logic mode, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                                    logic [POS_W-1:0] y, logic [Z_W-1:0] z);
         int n;
         int s;
         n = (slot_limit > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slot_limit);
         if (mode == MODE_CONTACT) begin
            s = find_slot(id, n);
            if (s < 0) begin
               awaited_replies.push_back(make_reply(KIND_ACK, 1'b1, 0, TID_FREE,
                                                    '0, '0, '0, 1'b1));
            end else begin
               owner[s]   = (z == '0) ? TID_FREE : {1'b0, id};
               pos_x[s]   = x;
               pos_y[s]   = y;
               pos_z[s]   = z;
               updated[s] = 1'b1;
               awaited_replies.push_back(make_reply(KIND_ACK, 1'b0, s, owner[s],
                                                    '0, '0, '0, 1'b1));
            end
         end else begin
            // walk the slots in use; marks past the limit stay set
            for (int i = 0; i < n; i++) begin
               if (updated[i]) begin
                  awaited_replies.push_back(make_reply(KIND_REPORT, 1'b0, i, owner[i],
                                                       pos_x[i], pos_y[i], pos_z[i], 1'b0));
                  updated[i] = 1'b0;
               end
            end
            awaited_replies.push_back(make_reply(KIND_SYNC, 1'b0, 0, '0, '0, '0, '0, 1'b1));
         end
      endfunction

      function bit same(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] data, logic [KIND_W-1:0] user,
                                logic last);
         touch_reply_type got;
         touch_reply_type want;
         bit ok;
         got.kind     = kind_type'(user);
         got.status   = data[0];
         got.slot     = data[4:1];
         got.tid      = data[21:5];
         got.x        = data[37:22];
         got.y        = data[53:38];
         got.has_pres = data[54];
         got.pres     = data[69:55];
         got.has_dist = data[70];
         got.dist_val = data[86:71];
         got.last     = last;
         if (awaited_replies.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got kind %0d data 0x%0h",
                     $time, user, data);
            error_count++;
            return;
         end
         want = awaited_replies.pop_front();
         ok = 1'b1;
         ok &= same("kind", want.kind, got.kind);
         ok &= same("status", want.status, got.status);
         ok &= same("slot_index", want.slot, got.slot);
         ok &= same("tracking_id", want.tid, got.tid);
         ok &= same("out_x", want.x, got.x);
         ok &= same("out_y", want.y, got.y);
         ok &= same("has_pressure", want.has_pres, got.has_pres);
         ok &= same("pressure", want.pres, got.pres);
         ok &= same("has_distance", want.has_dist, got.has_dist);
         ok &= same("distance", want.dist_val, got.dist_val);
         ok &= same("last", want.last, got.last);
         ok &= same("pad", 32'd0, data[87]);
         if (!ok) error_count++;
      endfunction
   endclass

   slot_reply_board       board;
   bit                    send_idle_on;
   bit                    recv_idle_on;
   int                    words_sent;
   int                    cycle_count;
   logic [ID_W-1:0]       id_pool [6];
   logic                  proto_plan [PLAN_LEN] = '{PROTO_B, PROTO_A, PROTO_B, PROTO_A,
                                                    PROTO_B, PROTO_A, PROTO_B, PROTO_B};
   logic [CSR_DATA_W-1:0] slot_plan [PLAN_LEN] = '{5'd16, 5'd16, 5'd4, 5'd3,
                                                   5'd1, 5'd31, 5'd9, 5'd0};

   // Mostly no gap, some short, a few long
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one word, hold it until accepted, then log it
   task automatic send_word(logic mode, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [Z_W-1:0] z);
      int gap;
      gap = pick_gap(send_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {z, y, x, id};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      board.predict_replies(mode, id, x, y, z);
      words_sent++;
   endtask

   task automatic send_flush();
      send_word(MODE_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Contact with a pooled id most of the time so protocol B finds its owner
   task automatic send_contact();
      logic [ID_W-1:0] id;
      logic [Z_W-1:0]  z;
      int              r;
      id = ($urandom_range(0, 99) < 80) ? id_pool[$urandom_range(0, 5)] : 16'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 15) begin
         z = '0;
      end else if (r < 55) begin
         z = 16'($urandom_range(1, 32767));
      end else if (r < 90) begin
         z = 16'(-$urandom_range(1, 32768));
      end else begin
         case ($urandom_range(0, 3))
            0:       z = 16'h7fff;
            1:       z = 16'h8000;
            2:       z = 16'h0001;
            default: z = 16'hffff;
         endcase
      end
      send_word(MODE_CONTACT, id, 16'($urandom), 16'($urandom), z);
   endtask

   // A frame of contacts closed by a flush; a few frames are bare or left open
   task automatic run_frame(int slot_cap);
      int count;
      count = $urandom_range(1, slot_cap + 2);
      if ($urandom_range(0, 99) < 8) count = 0;
      repeat (count) send_contact();
      if ($urandom_range(0, 99) < 90) send_flush();
   endtask

   // Drop valid, wait out every owed word, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      board.write_register(idx, val);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response stalls, changed on the falling edge
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = ($urandom_range(0, 99) < 60) ? pick_gap(recv_idle_on) : 0;
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Check every word the block hands over
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_reply(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int phase;
      int plan;
      int cap;
      int phase_end;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = MODE_CONTACT;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      words_sent   = 0;
      board        = new();
      foreach (id_pool[i]) id_pool[i] = 16'($urandom);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Protocol B at reset: extremes, owner match, lift-off, empty flush
      send_word(MODE_CONTACT, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
      send_word(MODE_CONTACT, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
      send_word(MODE_CONTACT, 16'h1234, 16'h0100, 16'h0200, 16'h8000);
      send_word(MODE_CONTACT, 16'h0000, 16'h0010, 16'h0020, 16'hffff);
      send_word(MODE_CONTACT, 16'hffff, 16'h5555, 16'haaaa, 16'h0000);
      send_flush();
      send_flush();
      send_word(MODE_CONTACT, 16'h0007, 16'h0abc, 16'h0def, 16'h0000);
      settle();

      // Protocol A, slot count above the table size, writes to unused indexes
      write_reg(CSR_PROTOCOL_TYPE, PROTO_A);
      write_reg(CSR_ACTIVE_SLOTS, 5'd31);
      write_reg(CSR_UNUSED_LO, 5'h1f);
      write_reg(CSR_UNUSED_HI, 5'h00);
      repeat (3) send_contact();
      settle();

      // One slot in use: marks past it survive the flush
      write_reg(CSR_ACTIVE_SLOTS, 5'd1);
      send_flush();
      send_contact();
      send_contact();
      settle();
      write_reg(CSR_ACTIVE_SLOTS, 5'd16);
      send_flush();
      settle();

      // No slots at all
      write_reg(CSR_ACTIVE_SLOTS, 5'd0);
      send_contact();
      send_flush();
      settle();

      // Protocol B with a single slot: second id finds nothing
      write_reg(CSR_PROTOCOL_TYPE, PROTO_B);
      write_reg(CSR_ACTIVE_SLOTS, 5'd1);
      send_word(MODE_CONTACT, 16'h0100, 16'h0001, 16'h0002, 16'h0005);
      send_word(MODE_CONTACT, 16'h0200, 16'h0003, 16'h0004, 16'hfff0);
      settle();

      // Random frames over a rotating set of register settings
      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         plan = phase % PLAN_LEN;
         write_reg(CSR_PROTOCOL_TYPE, proto_plan[plan]);
         write_reg(CSR_ACTIVE_SLOTS, slot_plan[plan]);
         if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                      5'($urandom));
         cap = (slot_plan[plan] > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slot_plan[plan]);
         foreach (id_pool[i]) id_pool[i] = 16'($urandom);
         send_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         recv_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         phase_end = words_sent + 33;
         while (words_sent < phase_end && words_sent < TOTAL_WORDS) run_frame(cap);
         settle();
         phase++;
      end

      if (board.error_count == 0 && board.outstanding() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
